>>> hw/rtl/vrv_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the vote record validator: phase codes, status codes,
// register indexes and register reset values. No dependencies.
package vrv_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned PctW     = 16;
   localparam int unsigned StatusW  = 2;
   localparam int unsigned PhaseW   = 3;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned RspDataW = 16;

   localparam logic [PhaseW-1:0] PH_COUNT = 3'd0;
   localparam logic [PhaseW-1:0] PH_NLEN  = 3'd1;
   localparam logic [PhaseW-1:0] PH_NAME  = 3'd2;
   localparam logic [PhaseW-1:0] PH_PLO   = 3'd3;
   localparam logic [PhaseW-1:0] PH_PHI   = 3'd4;
   localparam logic [PhaseW-1:0] PH_DONE  = 3'd5;
   localparam logic [PhaseW-1:0] PH_HOLD  = 3'd6;

   localparam logic [StatusW-1:0] ST_OK    = 2'd0;
   localparam logic [StatusW-1:0] ST_LEN   = 2'd1;
   localparam logic [StatusW-1:0] ST_ASSET = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_MAX_VOTES    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_NAME_LEN_MIN = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_NAME_LEN_MAX = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PERCENT_MIN  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_PERCENT_MAX  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_CHAR_LOW     = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_CHAR_HIGH    = 3'd6;

   localparam logic [ByteW-1:0] MAX_VOTES_RST    = 8'd53;
   localparam logic [ByteW-1:0] NAME_LEN_MIN_RST = 8'd1;
   localparam logic [ByteW-1:0] NAME_LEN_MAX_RST = 8'd20;
   localparam logic [PctW-1:0]  PERCENT_MIN_RST  = 16'd1;
   localparam logic [PctW-1:0]  PERCENT_MAX_RST  = 16'd10000;
   localparam logic [ByteW-1:0] CHAR_LOW_RST     = 8'd32;
   localparam logic [ByteW-1:0] CHAR_HIGH_RST    = 8'd126;

endpackage

>>> hw/rtl/vote_record_validator_core.sv
`timescale 1ns / 1ps
// Vote record validator: byte-serial parser that checks one serialized vote
// record and gives one status word at its last byte. Depends on vrv_pkg.
//
//   channel  direction  word
//   req      in         tdata[7:0] data_byte, tlast last_byte
//   rsp      out        tdata[1:0] status, [9:2] ballot_count, [15:10] zero
//   csr      in         csr_we, csr_index, csr_wdata (write only)
//
// One byte per cycle while no result is stalled; a byte is registered in the input
// register, and its status, if any, is registered in the result register as it leaves.
// The parse state update (compares and one 16-bit add) sets the cycle.
// Synchronous active-high reset clears parse state and restores registers.
// A stalled result holds a byte carrying tlast and the bytes behind it; others keep flowing.
module vote_record_validator_core
   import vrv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // last_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [1:0] status, [9:2] ballot_count
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic [ByteW-1:0] max_votes_ff, name_len_min_ff, name_len_max_ff;
   logic [ByteW-1:0] char_low_ff, char_high_ff;
   logic [PctW-1:0]  percent_min_ff, percent_max_ff;

   logic             in_valid_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             in_last_ff;
   logic             advance;

   logic [PhaseW-1:0]  phase_ff, phase_in;
   logic [ByteW-1:0]   count_seen_ff, count_seen_in;
   logic [ByteW-1:0]   votes_left_ff, votes_left_in;
   logic [ByteW-1:0]   name_left_ff, name_left_in;
   logic               name_bad_ff, name_bad_in;
   logic [ByteW-1:0]   pct_low_ff, pct_low_in;
   logic [PctW-1:0]    total_ff, total_in;
   logic [StatusW-1:0] latched_ff, latched_in;

   logic               rsp_valid_ff;
   logic [StatusW-1:0] rsp_status_ff, status_out;
   logic [ByteW-1:0]   rsp_count_ff;

   logic [PctW-1:0]  pct;
   logic [PctW-1:0]  total_sum;
   logic [ByteW-1:0] votes_dec;
   logic [ByteW-1:0] name_dec;
   logic             char_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_votes_ff    <= MAX_VOTES_RST;
         name_len_min_ff <= NAME_LEN_MIN_RST;
         name_len_max_ff <= NAME_LEN_MAX_RST;
         percent_min_ff  <= PERCENT_MIN_RST;
         percent_max_ff  <= PERCENT_MAX_RST;
         char_low_ff     <= CHAR_LOW_RST;
         char_high_ff    <= CHAR_HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_VOTES:    max_votes_ff    <= csr_wdata[ByteW-1:0];
            CSR_NAME_LEN_MIN: name_len_min_ff <= csr_wdata[ByteW-1:0];
            CSR_NAME_LEN_MAX: name_len_max_ff <= csr_wdata[ByteW-1:0];
            CSR_PERCENT_MIN:  percent_min_ff  <= csr_wdata[PctW-1:0];
            CSR_PERCENT_MAX:  percent_max_ff  <= csr_wdata[PctW-1:0];
            CSR_CHAR_LOW:     char_low_ff     <= csr_wdata[ByteW-1:0];
            CSR_CHAR_HIGH:    char_high_ff    <= csr_wdata[ByteW-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   assign pct       = {in_byte_ff, pct_low_ff};
   assign total_sum = total_ff + pct;
   assign votes_dec = votes_left_ff - 8'd1;
   assign name_dec  = name_left_ff - 8'd1;
   assign char_bad  = (in_byte_ff < char_low_ff) || (in_byte_ff > char_high_ff);

   always_comb begin
      phase_in      = phase_ff;
      count_seen_in = count_seen_ff;
      votes_left_in = votes_left_ff;
      name_left_in  = name_left_ff;
      name_bad_in   = name_bad_ff;
      pct_low_in    = pct_low_ff;
      total_in      = total_ff;
      latched_in    = latched_ff;
      unique case (phase_ff)
         PH_COUNT: begin
            count_seen_in = in_byte_ff;
            if (in_byte_ff == '0) begin
               latched_in = ST_OK;
               phase_in   = PH_HOLD;
            end else if (in_byte_ff > max_votes_ff) begin
               latched_in = ST_ASSET;
               phase_in   = PH_HOLD;
            end else begin
               votes_left_in = in_byte_ff;
               total_in      = '0;
               phase_in      = PH_NLEN;
            end
         end
         PH_NLEN: begin
            if (in_byte_ff < name_len_min_ff || in_byte_ff > name_len_max_ff) begin
               latched_in = ST_ASSET;
               phase_in   = PH_HOLD;
            end else begin
               name_left_in = in_byte_ff;
               name_bad_in  = 1'b0;
               phase_in     = (in_byte_ff == '0) ? PH_PLO : PH_NAME;
            end
         end
         PH_NAME: begin
            name_bad_in  = name_bad_ff || char_bad;
            name_left_in = name_dec;
            if (name_dec == '0) begin
               if (name_bad_ff || char_bad) begin
                  phase_in   = PH_HOLD;
                  latched_in = ST_ASSET;
               end else begin
                  phase_in = PH_PLO;
               end
            end
         end
         PH_PLO: begin
            pct_low_in = in_byte_ff;
            phase_in   = PH_PHI;
         end
         PH_PHI: begin
            if (pct < percent_min_ff || pct > percent_max_ff) begin
               latched_in = ST_ASSET;
               phase_in   = PH_HOLD;
            end else begin
               total_in      = total_sum;
               votes_left_in = votes_dec;
               if (votes_dec != '0) begin
                  phase_in = PH_NLEN;
               end else if (total_sum != percent_max_ff) begin
                  latched_in = ST_ASSET;
                  phase_in   = PH_HOLD;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_DONE: begin
            latched_in = ST_LEN;
            phase_in   = PH_HOLD;
         end
         default: phase_in = PH_HOLD;
      endcase
   end

   always_comb begin
      if (phase_in == PH_HOLD) begin
         status_out = latched_in;
      end else if (phase_in == PH_DONE) begin
         status_out = ST_OK;
      end else begin
         status_out = ST_LEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && in_last_ff)) begin
         phase_ff      <= PH_COUNT;
         count_seen_ff <= '0;
         votes_left_ff <= '0;
         name_left_ff  <= '0;
         name_bad_ff   <= 1'b0;
         pct_low_ff    <= '0;
         total_ff      <= '0;
         latched_ff    <= ST_OK;
      end else if (advance) begin
         phase_ff      <= phase_in;
         count_seen_ff <= count_seen_in;
         votes_left_ff <= votes_left_in;
         name_left_ff  <= name_left_in;
         name_bad_ff   <= name_bad_in;
         pct_low_ff    <= pct_low_in;
         total_ff      <= total_in;
         latched_ff    <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_status_ff <= status_out;
         rsp_count_ff  <= count_seen_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - StatusW - ByteW){1'b0}}, rsp_count_ff, rsp_status_ff};

endmodule
